/* design/assert_macros.svh */
// Assertion macros for the RTL files.
// Depends on nothing; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mmpe_pkg.sv */
// Shared types and constants for the min/max pyramid encoder.
// No dependencies.
package mmpe_pkg;

    localparam int MAX_LEVELS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int SAMPLE_W        = 32;
    localparam int LEVEL_W         = 5;
    localparam int POS_W           = 15;
    localparam int KIND_W          = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ORDER  = 2'd0,
        KIND_DETAIL = 2'd1,
        KIND_TOP    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PAIR,
        S_FLOOK,
        S_FPAIR,
        S_TOP
    } state_t;

endpackage

/* design/mmpe_pair_unit.sv */
// Pairs a pending (left) element with an incoming (right) element:
// order flag, min/max details and merged aggregate. Uses mmpe_pkg.
module mmpe_pair_unit #(
    parameter int SAMPLE_BITS = mmpe_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] lmin,
    input  logic signed [SAMPLE_BITS-1:0] lmax,
    input  logic signed [SAMPLE_BITS-1:0] rmin,
    input  logic signed [SAMPLE_BITS-1:0] rmax,
    output logic                          left_below,
    output logic signed [SAMPLE_BITS:0]   dmin,
    output logic signed [SAMPLE_BITS:0]   dmax,
    output logic signed [SAMPLE_BITS-1:0] mmin,
    output logic signed [SAMPLE_BITS-1:0] mmax
);

    logic lmax_above;

    assign left_below = lmin < rmin;
    assign lmax_above = lmax > rmax;
    assign dmin = {lmin[SAMPLE_BITS-1], lmin} - {rmin[SAMPLE_BITS-1], rmin};
    assign dmax = {lmax[SAMPLE_BITS-1], lmax} - {rmax[SAMPLE_BITS-1], rmax};
    assign mmin = left_below ? lmin : rmin;
    assign mmax = lmax_above ? lmax : rmax;

endmodule

/* design/minmax_pyramid_encoder_top.sv */
// Min/max pyramid encoder top level; pending aggregates in a one-port RAM.
// Depends on mmpe_pkg, mmpe_pair_unit and assert_macros.svh.
//
// One sample at a time: a sample is accepted, paired at each of the k
// occupied low levels in turn (k in 0..MAX_LEVELS-1) and then stored at the
// first empty level. A last sample then starts a flush over all MAX_LEVELS
// levels: the first occupied level seeds the aggregate and each later one is
// paired into it, and the top aggregate ends the run. Each pair waits for the
// pending RAM's registered read. A stalled output register holds the
// sequencer only when a new result is due. A full pyramid drops the sample.
`include "assert_macros.svh"

module minmax_pyramid_encoder_top #(
    parameter int MAX_LEVELS  = mmpe_pkg::MAX_LEVELS_DEF,
    parameter int SAMPLE_BITS = mmpe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mmpe_pkg::SAMPLE_W-1:0]      sample,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mmpe_pkg::KIND_W-1:0]        kind,
    output logic [mmpe_pkg::LEVEL_W-1:0]       level,
    output logic [mmpe_pkg::POS_W-1:0]         position,
    output logic signed [SAMPLE_BITS:0]        value_a,
    output logic signed [SAMPLE_BITS:0]        value_b,
    output logic                               order_flag,
    output logic                               overflow,
    output logic                               end_of_run
);

    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CLW = $clog2(MAX_LEVELS + 1);
    localparam logic [LW-1:0] LV_TOP = LW'(MAX_LEVELS - 1);

    mmpe_pkg::state_t state_reg, state_next;

    logic [MAX_LEVELS-1:0]           pend_reg, pend_next;
    logic [mmpe_pkg::POS_W-1:0]      cnt_reg [MAX_LEVELS];
    logic [mmpe_pkg::POS_W-1:0]      cnt_next [MAX_LEVELS];
    logic [LW-1:0]                   lv_reg, lv_next;
    logic [CLW-1:0]                  clevel_reg, clevel_next;
    logic                            have_reg, have_next;
    logic                            last_reg, last_next;
    logic                            drop_reg, drop_next;
    logic signed [SAMPLE_BITS-1:0]   cmin_reg, cmin_next;
    logic signed [SAMPLE_BITS-1:0]   cmax_reg, cmax_next;

    // pending aggregate RAM, {max, min}
    logic [2*SAMPLE_BITS-1:0]        mem [MAX_LEVELS];
    logic [2*SAMPLE_BITS-1:0]        rdata_reg;
    logic                            mem_wr, mem_rd;

    // output register
    logic                            ov_reg, ov_next;
    logic [mmpe_pkg::KIND_W-1:0]     okind_reg, okind_next;
    logic [mmpe_pkg::LEVEL_W-1:0]    olevel_reg, olevel_next;
    logic [mmpe_pkg::POS_W-1:0]      opos_reg, opos_next;
    logic signed [SAMPLE_BITS:0]     oa_reg, oa_next;
    logic signed [SAMPLE_BITS:0]     ob_reg, ob_next;
    logic                            oflag_reg, oflag_next;
    logic                            oovf_reg, oovf_next;
    logic                            oeor_reg, oeor_next;

    logic                            out_free, in_take, pend_lv, pend_up;
    logic [LW-1:0]                   lv_inc;
    logic signed [SAMPLE_BITS-1:0]   lmin, lmax;
    logic                            p_below;
    logic signed [SAMPLE_BITS:0]     p_dmin, p_dmax;
    logic signed [SAMPLE_BITS-1:0]   p_mmin, p_mmax;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = state_reg != mmpe_pkg::S_IDLE;
    assign in_take  = in_valid && !in_stall;
    assign pend_lv  = pend_reg[lv_reg];
    assign lv_inc   = lv_reg + LW'(1);
    assign pend_up  = (lv_reg != LV_TOP) && pend_reg[lv_inc];
    assign lmin     = rdata_reg[SAMPLE_BITS-1:0];
    assign lmax     = rdata_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];

    mmpe_pair_unit #(.SAMPLE_BITS(SAMPLE_BITS)) u_pair (
        .lmin       (lmin),
        .lmax       (lmax),
        .rmin       (cmin_reg),
        .rmax       (cmax_reg),
        .left_below (p_below),
        .dmin       (p_dmin),
        .dmax       (p_dmax),
        .mmin       (p_mmin),
        .mmax       (p_mmax)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmpe_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    if (&pend_reg)
                        state_next = last ? mmpe_pkg::S_FLOOK : mmpe_pkg::S_IDLE;
                    else
                        state_next = mmpe_pkg::S_LOOK;
                end
            end
            mmpe_pkg::S_LOOK:
            begin
                if (pend_lv)
                    state_next = mmpe_pkg::S_PAIR;
                else
                    state_next = last_reg ? mmpe_pkg::S_FLOOK : mmpe_pkg::S_IDLE;
            end
            mmpe_pkg::S_PAIR:
            begin
                if (out_free)
                    state_next = mmpe_pkg::S_LOOK;
            end
            mmpe_pkg::S_FLOOK:
            begin
                if (pend_lv)
                    state_next = mmpe_pkg::S_FPAIR;
                else if (lv_reg == LV_TOP)
                    state_next = mmpe_pkg::S_TOP;
            end
            mmpe_pkg::S_FPAIR:
            begin
                if (out_free || !have_reg)
                    state_next = (lv_reg == LV_TOP) ? mmpe_pkg::S_TOP : mmpe_pkg::S_FLOOK;
            end
            mmpe_pkg::S_TOP:
            begin
                if (out_free)
                    state_next = mmpe_pkg::S_IDLE;
            end
            default: state_next = mmpe_pkg::S_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        lv_next     = lv_reg;
        clevel_next = clevel_reg;
        have_next   = have_reg;
        last_next   = last_reg;
        drop_next   = drop_reg;
        cmin_next   = cmin_reg;
        cmax_next   = cmax_reg;
        mem_wr      = 1'b0;
        mem_rd      = 1'b0;
        ov_next     = ov_reg && out_stall;
        okind_next  = okind_reg;
        olevel_next = olevel_reg;
        opos_next   = opos_reg;
        oa_next     = oa_reg;
        ob_next     = ob_reg;
        oflag_next  = oflag_reg;
        oovf_next   = oovf_reg;
        oeor_next   = oeor_reg;
        case (state_reg)
            mmpe_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    cmin_next = SAMPLE_BITS'(sample);
                    cmax_next = SAMPLE_BITS'(sample);
                    last_next = last;
                    lv_next   = '0;
                    have_next = 1'b0;
                    if (&pend_reg)
                        drop_next = 1'b1;
                end
            end
            mmpe_pkg::S_LOOK:
            begin
                if (pend_lv)
                    mem_rd = 1'b1;
                else
                begin
                    mem_wr           = 1'b1;
                    pend_next[lv_reg] = 1'b1;
                    lv_next          = '0;
                end
            end
            mmpe_pkg::S_PAIR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = (lv_reg == '0) ? mmpe_pkg::KIND_ORDER : mmpe_pkg::KIND_DETAIL;
                    olevel_next = mmpe_pkg::LEVEL_W'(lv_reg);
                    opos_next  = cnt_reg[lv_reg];
                    oa_next    = (lv_reg == '0) ? '0 : p_dmin;
                    ob_next    = (lv_reg == '0) ? '0 : p_dmax;
                    oflag_next = (lv_reg == '0) && p_below;
                    oovf_next  = drop_reg;
                    oeor_next  = !last_reg && !pend_up;
                    cnt_next[lv_reg]  = cnt_reg[lv_reg] + mmpe_pkg::POS_W'(1);
                    pend_next[lv_reg] = 1'b0;
                    cmin_next  = p_mmin;
                    cmax_next  = p_mmax;
                    lv_next    = lv_inc;
                end
            end
            mmpe_pkg::S_FLOOK:
            begin
                if (pend_lv)
                    mem_rd = 1'b1;
                else if (lv_reg != LV_TOP)
                    lv_next = lv_inc;
            end
            mmpe_pkg::S_FPAIR:
            begin
                if (!have_reg)
                begin
                    cmin_next   = lmin;
                    cmax_next   = lmax;
                    clevel_next = CLW'(lv_reg);
                    have_next   = 1'b1;
                    pend_next[lv_reg] = 1'b0;
                    lv_next     = lv_inc;
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = (lv_reg == '0) ? mmpe_pkg::KIND_ORDER : mmpe_pkg::KIND_DETAIL;
                    olevel_next = mmpe_pkg::LEVEL_W'(lv_reg);
                    opos_next  = cnt_reg[lv_reg];
                    oa_next    = (lv_reg == '0) ? '0 : p_dmin;
                    ob_next    = (lv_reg == '0) ? '0 : p_dmax;
                    oflag_next = (lv_reg == '0) && p_below;
                    oovf_next  = drop_reg;
                    oeor_next  = 1'b0;
                    cnt_next[lv_reg]  = cnt_reg[lv_reg] + mmpe_pkg::POS_W'(1);
                    pend_next[lv_reg] = 1'b0;
                    cmin_next   = p_mmin;
                    cmax_next   = p_mmax;
                    clevel_next = CLW'(lv_reg) + CLW'(1);
                    lv_next     = lv_inc;
                end
            end
            mmpe_pkg::S_TOP:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = mmpe_pkg::KIND_TOP;
                    olevel_next = mmpe_pkg::LEVEL_W'(clevel_reg);
                    opos_next   = '0;
                    oa_next     = {cmin_reg[SAMPLE_BITS-1], cmin_reg};
                    ob_next     = {cmax_reg[SAMPLE_BITS-1], cmax_reg};
                    oflag_next  = 1'b0;
                    oovf_next   = drop_reg;
                    oeor_next   = 1'b1;
                    // series done: pending, drop and aggregate flags and position counts back to reset values
                    pend_next   = '0;
                    drop_next   = 1'b0;
                    have_next   = 1'b0;
                    for (int i = 0; i < MAX_LEVELS; i++)
                        cnt_next[i] = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmpe_pkg::S_IDLE;
            pend_reg  <= '0;
            drop_reg  <= 1'b0;
            have_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            lv_reg    <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            drop_reg  <= drop_next;
            have_reg  <= have_next;
            ov_reg    <= ov_next;
            lv_reg    <= lv_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clevel_reg <= clevel_next;
        last_reg   <= last_next;
        cmin_reg   <= cmin_next;
        cmax_reg   <= cmax_next;
        okind_reg  <= okind_next;
        olevel_reg <= olevel_next;
        opos_reg   <= opos_next;
        oa_reg     <= oa_next;
        ob_reg     <= ob_next;
        oflag_reg  <= oflag_next;
        oovf_reg   <= oovf_next;
        oeor_reg   <= oeor_next;
    end

    // reads and writes never target one entry in the same cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[lv_reg] <= {cmax_reg, cmin_reg};
        if (mem_rd)
            rdata_reg <= mem[lv_reg];
    end

    assign out_valid  = ov_reg;
    assign kind       = okind_reg;
    assign level      = olevel_reg;
    assign position   = opos_reg;
    assign value_a    = oa_reg;
    assign value_b    = ob_reg;
    assign order_flag = oflag_reg;
    assign overflow   = oovf_reg;
    assign end_of_run = oeor_reg;

    `CHK_IMPL(a_top_ends_run, clk, rst_n, out_valid && kind == mmpe_pkg::KIND_TOP,
        end_of_run, "top aggregate not marked end of run")
    `CHK_IMPL(a_order_clean, clk, rst_n, out_valid && kind == mmpe_pkg::KIND_ORDER,
        level == '0 && value_a == '0 && value_b == '0, "order flag result has data")
    `CHK_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall && !(&pend_reg),
        state_reg == mmpe_pkg::S_LOOK, "accepted sample not processed")
    `CHK_IMPL(a_top_has_agg, clk, rst_n, state_reg == mmpe_pkg::S_TOP,
        have_reg, "flush reached top with no aggregate")

endmodule
